// ===== rtl/dbd_pkg.sv =====
// types, constants and calendar tables shared by the date distance block
package dbd_pkg;

   localparam int DayW    = 5;
   localparam int MonthW  = 4;
   localparam int YearW   = 14;
   localparam int SpanW   = 23;
   localparam int Q100W   = 8;
   localparam int Q400W   = 6;
   localparam int AdjW    = 13;
   localparam int MoOffW  = 9;
   localparam int ProdW   = 27;

   // reciprocal of 100 scaled by 2**19, exact for every year below 43690
   localparam logic [12:0] Recip100 = 13'd5243;
   localparam int          Shift100 = 19;
   localparam int          Shift400 = 21;

   localparam logic [MonthW-1:0] MonthJan = 4'd1;
   localparam logic [MonthW-1:0] MonthFeb = 4'd2;
   localparam logic [MonthW-1:0] MonthDec = 4'd12;

   // one calendar date as it arrives
   typedef struct packed {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
   } date_type;

   // after the century quotients
   typedef struct packed {
      date_type         date;
      logic [Q100W-1:0] q100;
      logic [Q400W-1:0] q400;
   } quot_type;

   // pieces of the day number plus the validity of the date
   typedef struct packed {
      logic [SpanW-1:0]  year_base;
      logic [AdjW-1:0]   year_adj;
      logic [MoOffW-1:0] month_off;
      logic [DayW-1:0]   day;
      logic              ok;
   } part_type;

   // days in the months before the given month of a common year
   function automatic logic [MoOffW-1:0] days_before_month(input logic [MonthW-1:0] m);
      logic [MoOffW-1:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // length of the given month of a common year, zero for a month that does not exist
   function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m);
      logic [DayW-1:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
         4'd2:                                      r = 5'd28;
         default:                                   r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/days_between_dates_top.sv =====
// top level: four-stage pipeline giving the day distance between two dates
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  two dates (day, month, year)
//  rsp_      out        rsp_valid/rsp_stall  dates_valid, day_span
//
// one item per cycle sustained while the output is not stalled
// stage 1 year times reciprocal, stage 2 leap year, date check, year and month terms,
// stage 3 day numbers, stage 4 difference into the output register
// reset empties all stages; payload registers are not reset
// a stall holds only full stages: empty stages still fill, so items keep entering
// until every stage holds an item
module days_between_dates_top
   import dbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DayW-1:0]      req_first_day,
   input  logic [MonthW-1:0]    req_first_month,
   input  logic [YearW-1:0]     req_first_year,
   input  logic [DayW-1:0]      req_second_day,
   input  logic [MonthW-1:0]    req_second_month,
   input  logic [YearW-1:0]     req_second_year,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_dates_valid,
   output logic [SpanW-1:0]     rsp_day_span
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   date_type         date_in [2];
   quot_type         s1_in [2];
   quot_type         s1_ff [2];
   part_type         s2_in [2];
   part_type         s2_ff [2];
   logic [SpanW-1:0] s3_num_in [2];
   logic [SpanW-1:0] s3_num_ff [2];
   logic             s3_ok_in, s3_ok_ff;
   logic             s4_ok_in, s4_ok_ff;
   logic [SpanW-1:0] s4_span_in, s4_span_ff;

   // a stage may load when it is empty or the one after it moves on
   assign rdy4      = !s4_valid_ff || !rsp_stall;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   assign date_in[0] = '{day: req_first_day, month: req_first_month, year: req_first_year};
   assign date_in[1] = '{day: req_second_day, month: req_second_month, year: req_second_year};

   // stage 1: century quotients by reciprocal multiplication
   always_comb begin
      logic [ProdW-1:0] prod;
      for (int i = 0; i < 2; i++) begin
         prod = ProdW'(date_in[i].year) * ProdW'(Recip100);
         s1_in[i].date = date_in[i];
         s1_in[i].q100 = prod[Shift100 +: Q100W];
         s1_in[i].q400 = prod[Shift400 +: Q400W];
      end
   end

   // stage 2: leap year, date check, year and month terms of the day number
   always_comb begin
      logic [YearW-1:0]  y;
      logic [YearW:0]    back100, back400;
      logic              nz100, nz400, nz4, leap;
      logic [AdjW-1:0]   c4, c100, c400;
      logic [DayW-1:0]   len;
      logic              month_ok;
      for (int i = 0; i < 2; i++) begin
         y        = s1_ff[i].date.year;
         back100  = (YearW+1)'(s1_ff[i].q100) * (YearW+1)'(100);
         back400  = (YearW+1)'(s1_ff[i].q400) * (YearW+1)'(400);
         nz100    = back100 != {1'b0, y};
         nz400    = back400 != {1'b0, y};
         nz4      = y[1:0] != 2'b00;
         leap     = (!nz4 && nz100) || !nz400;
         c4       = AdjW'(y >> 2) + AdjW'(nz4);
         c100     = AdjW'(s1_ff[i].q100) + AdjW'(nz100);
         c400     = AdjW'(s1_ff[i].q400) + AdjW'(nz400);
         month_ok = s1_ff[i].date.month >= MonthJan && s1_ff[i].date.month <= MonthDec;
         len      = month_length(s1_ff[i].date.month)
                    + DayW'(s1_ff[i].date.month == MonthFeb && leap);
         s2_in[i].year_base = SpanW'(y) * SpanW'(365);
         s2_in[i].year_adj  = c4 - c100 + c400;
         s2_in[i].month_off = days_before_month(s1_ff[i].date.month)
                              + MoOffW'(s1_ff[i].date.month > MonthFeb && leap);
         s2_in[i].day       = s1_ff[i].date.day;
         s2_in[i].ok        = month_ok && s1_ff[i].date.day != '0
                              && s1_ff[i].date.day <= len;
      end
   end

   // stage 3: day numbers counted from the first of January of year zero
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_num_in[i] = s2_ff[i].year_base + SpanW'(s2_ff[i].year_adj)
                        + SpanW'(s2_ff[i].month_off) + SpanW'(s2_ff[i].day) - SpanW'(1);
      end
      s3_ok_in = s2_ff[0].ok && s2_ff[1].ok;
   end

   // stage 4: absolute difference, forced to zero for a bad date
   always_comb begin
      s4_ok_in = s3_ok_ff;
      if (!s3_ok_ff) begin
         s4_span_in = '0;
      end else if (s3_num_ff[0] > s3_num_ff[1]) begin
         s4_span_in = s3_num_ff[0] - s3_num_ff[1];
      end else begin
         s4_span_in = s3_num_ff[1] - s3_num_ff[0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) begin
         s3_num_ff <= s3_num_in;
         s3_ok_ff  <= s3_ok_in;
      end
      if (rdy4) begin
         s4_ok_ff   <= s4_ok_in;
         s4_span_ff <= s4_span_in;
      end
   end

   assign rsp_valid       = s4_valid_ff;
   assign rsp_dates_valid = s4_ok_ff;
   assign rsp_day_span    = s4_span_ff;

   // a rejected pair of dates never reports a distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dates_valid |-> rsp_day_span == '0)
      else $error("nonzero span for invalid dates");

   // the input side stalls only when every stage holds an item and the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // with the output free while it moves through the stages, an accepted item reaches the output
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item lost in pipeline");

   // the span never exceeds 5996178 days
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_span <= SpanW'(5996178))
      else $error("span out of range");

endmodule
